/* src/chord_note_splitter_core_defines.svh */
`ifndef CHORD_NOTE_SPLITTER_CORE_DEFINES_SVH
`define CHORD_NOTE_SPLITTER_CORE_DEFINES_SVH

// Concurrent check on the block clock, no reset qualifier.
`define CSPLIT_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Concurrent check on the block clock, off while reset is asserted.
`define CSPLIT_ASSERT(lbl, prop, msg) \
  `CSPLIT_ASSERT_NORST(lbl, disable iff (!rst_ni) prop, msg)

`endif

/* src/csplit_pkg.sv */
`default_nettype none

package csplit_pkg;

  // Default depth of each chord part store
  localparam int unsigned PART_MAX_DEF = 32;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Biased pitch: pitch + 12, range 0..47
  localparam int unsigned PITCH_W = 6;
  localparam logic [PITCH_W-1:0] OCTAVE = 6'd12;
  localparam logic [PITCH_W-1:0] LOWER_BIAS = 6'd24;

  // Characters
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Semitone of letters A..G, indexed by the low three bits of the ASCII code
  // (code 0 is not a letter and reads as zero)
  localparam logic [3:0] LETTER_PITCH [8] = '{
    4'd0, 4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7
  };

  // Status from datapath to controller
  typedef struct packed {
    logic is_open;
    logic is_close;
    logic is_nl;
    logic is_letter;
    logic first_full;
    logic second_full;
    logic emit_last;
  } csplit_status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_len;
    logic first_start;
    logic first_mod;
    logic first_append;
    logic second_start;
    logic second_mod;
    logic second_append;
    logic emit_start;
    logic emit_step;
    logic load_echo;
    logic load_err;
  } csplit_cmd_t;

  // A..G or a..g
  function automatic logic is_note_letter(input logic [7:0] b);
    return ((b[7:3] == 5'b01000) || (b[7:3] == 5'b01100)) && (b[2:0] != 3'd0);
  endfunction

  // Biased pitch of a note letter; lower case sits one octave up
  function automatic logic [PITCH_W-1:0] letter_value(input logic [7:0] b);
    logic [PITCH_W-1:0] base;
    base = {2'b00, LETTER_PITCH[b[2:0]]};
    return base + (b[5] ? LOWER_BIAS : OCTAVE);
  endfunction

endpackage

`default_nettype wire

/* src/csplit_dp.sv */
`default_nettype none

module csplit_dp #(
  parameter int unsigned PART_MAX = csplit_pkg::PART_MAX_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [7:0]                  byte_i,
  input  wire csplit_pkg::csplit_cmd_t     cmd_i,
  output csplit_pkg::csplit_status_t       status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_bit_i,
  output logic                             select_high_o,
  output logic [7:0]                       out_byte_o,
  output logic                             out_err_o,
  output logic                             out_last_o
);

  localparam int unsigned IDX_W     = $clog2(PART_MAX);
  localparam int unsigned LEN_W     = $clog2(PART_MAX + 1);
  localparam int unsigned MEM_AW    = IDX_W + 1;
  localparam int unsigned MEM_DEPTH = 2 ** MEM_AW;
  localparam int unsigned PW        = csplit_pkg::PITCH_W;

  logic                select_high_q;
  logic [LEN_W-1:0]    len1_q, len2_q;
  logic [PW-1:0]       p1_q, p1_d, p2_q, p2_d;
  logic [IDX_W-1:0]    emit_idx_q;
  logic [7:0]          mem_q [MEM_DEPTH];
  logic [7:0]          out_byte_q;
  logic                out_err_q, out_last_q;

  logic                is_comma, is_apos;
  logic [PW-1:0]       byte_pitch;
  logic                wr_en, wr_part, first_low, use_first, emit_last;
  logic [IDX_W-1:0]    wr_idx;
  logic [MEM_AW-1:0]   wr_addr, rd_addr;
  logic [LEN_W-1:0]    emit_len;

  // Byte classification
  assign is_comma   = (byte_i == csplit_pkg::CH_COMMA);
  assign is_apos    = (byte_i == csplit_pkg::CH_APOS);
  assign byte_pitch = csplit_pkg::letter_value(byte_i);

  // Part selection for the chord close
  assign first_low = (p1_q <= p2_q);
  assign use_first = select_high_q ? !first_low : first_low;
  assign emit_len  = use_first ? len1_q : len2_q;
  assign emit_last = ((LEN_W'(emit_idx_q) + LEN_W'(1)) == emit_len);

  always_comb begin
    status_o             = '0;
    status_o.is_open     = (byte_i == csplit_pkg::CH_OPEN);
    status_o.is_close    = (byte_i == csplit_pkg::CH_CLOSE);
    status_o.is_nl       = (byte_i == csplit_pkg::CH_NL);
    status_o.is_letter   = csplit_pkg::is_note_letter(byte_i);
    status_o.first_full  = (len1_q == LEN_W'(PART_MAX));
    status_o.second_full = (len2_q == LEN_W'(PART_MAX));
    status_o.emit_last   = emit_last;
  end

  // Store addressing: upper half holds part two
  assign wr_en   = cmd_i.first_start | cmd_i.first_append |
                   cmd_i.second_start | cmd_i.second_append;
  assign wr_part = cmd_i.second_start | cmd_i.second_append;
  always_comb begin
    priority if (cmd_i.first_start || cmd_i.second_start) begin
      wr_idx = '0;
    end else if (wr_part) begin
      wr_idx = len2_q[IDX_W-1:0];
    end else begin
      wr_idx = len1_q[IDX_W-1:0];
    end
  end
  assign wr_addr = {wr_part, wr_idx};
  assign rd_addr = {!use_first, emit_idx_q};

  // Pitch updates: letter sets it, the byte after may shift an octave
  always_comb begin
    p1_d = p1_q;
    if (cmd_i.first_start) begin
      p1_d = byte_pitch;
    end else if (cmd_i.first_mod) begin
      if (is_comma) begin
        p1_d = p1_q - csplit_pkg::OCTAVE;
      end else if (is_apos) begin
        p1_d = p1_q + csplit_pkg::OCTAVE;
      end
    end
  end

  always_comb begin
    p2_d = p2_q;
    if (cmd_i.second_start) begin
      p2_d = byte_pitch;
    end else if (cmd_i.second_mod) begin
      if (is_comma) begin
        p2_d = p2_q - csplit_pkg::OCTAVE;
      end else if (is_apos) begin
        p2_d = p2_q + csplit_pkg::OCTAVE;
      end
    end
  end

  // Config, lengths and pitches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_high_q <= 1'b0;
      len1_q        <= '0;
      len2_q        <= '0;
      p1_q          <= '0;
      p2_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        select_high_q <= cfg_bit_i;
      end
      if (cmd_i.clear_len) begin
        len1_q <= '0;
        len2_q <= '0;
      end
      if (cmd_i.first_start) begin
        len1_q <= LEN_W'(1);
      end else if (cmd_i.first_append) begin
        len1_q <= len1_q + LEN_W'(1);
      end
      if (cmd_i.second_start) begin
        len2_q <= LEN_W'(1);
      end else if (cmd_i.second_append) begin
        len2_q <= len2_q + LEN_W'(1);
      end
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // Emission index
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      emit_idx_q <= '0;
    end else if (cmd_i.emit_step) begin
      emit_idx_q <= emit_idx_q + IDX_W'(1);
    end
  end

  // Part store and output word register (registered read)
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= byte_i;
    end
    priority if (cmd_i.emit_step) begin
      out_byte_q <= mem_q[rd_addr];
      out_err_q  <= 1'b0;
      out_last_q <= emit_last;
    end else if (cmd_i.load_echo) begin
      out_byte_q <= byte_i;
      out_err_q  <= 1'b0;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_err) begin
      out_byte_q <= '0;
      out_err_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign select_high_o = select_high_q;
  assign out_byte_o    = out_byte_q;
  assign out_err_o     = out_err_q;
  assign out_last_o    = out_last_q;

endmodule

`default_nettype wire

/* src/csplit_ctrl.sv */
`default_nettype none

`include "chord_note_splitter_core_defines.svh"

module csplit_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  input  wire csplit_pkg::csplit_status_t status_i,
  output csplit_pkg::csplit_cmd_t         cmd_o
);

  localparam logic [2:0] ST_OUTSIDE    = 3'd0;
  localparam logic [2:0] ST_WANT_FIRST = 3'd1;
  localparam logic [2:0] ST_FIRST_MOD  = 3'd2;
  localparam logic [2:0] ST_IN_FIRST   = 3'd3;
  localparam logic [2:0] ST_SECOND_MOD = 3'd4;
  localparam logic [2:0] ST_IN_SECOND  = 3'd5;
  localparam logic [2:0] ST_EMIT       = 3'd6;
  localparam logic [2:0] ST_HALTED     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free, accept, load;

  // Output word register is free when empty or being taken
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_HALTED) || ((state_q != ST_EMIT) && slot_free);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_OUTSIDE: begin
        if (accept) begin
          if (status_i.is_open) begin
            cmd_o.clear_len = 1'b1;
            state_d         = ST_WANT_FIRST;
          end else begin
            cmd_o.load_echo = 1'b1;
          end
        end
      end
      ST_WANT_FIRST: begin
        if (accept) begin
          if (status_i.is_letter) begin
            cmd_o.first_start = 1'b1;
            state_d           = ST_FIRST_MOD;
          end else begin
            cmd_o.load_err = 1'b1;
            state_d        = ST_HALTED;
          end
        end
      end
      ST_FIRST_MOD, ST_IN_FIRST: begin
        if (accept) begin
          cmd_o.first_mod = (state_q == ST_FIRST_MOD);
          priority if (status_i.is_close || status_i.is_nl) begin
            cmd_o.load_err = 1'b1;
            state_d        = ST_HALTED;
          end else if (status_i.is_letter) begin
            cmd_o.second_start = 1'b1;
            state_d            = ST_SECOND_MOD;
          end else if (status_i.first_full) begin
            cmd_o.load_err = 1'b1;
            state_d        = ST_HALTED;
          end else begin
            cmd_o.first_append = 1'b1;
            state_d            = ST_IN_FIRST;
          end
        end
      end
      ST_SECOND_MOD, ST_IN_SECOND: begin
        if (accept) begin
          cmd_o.second_mod = (state_q == ST_SECOND_MOD);
          priority if (status_i.is_nl) begin
            cmd_o.load_err = 1'b1;
            state_d        = ST_HALTED;
          end else if (status_i.is_close) begin
            cmd_o.emit_start = 1'b1;
            state_d          = ST_EMIT;
          end else if (status_i.second_full) begin
            cmd_o.load_err = 1'b1;
            state_d        = ST_HALTED;
          end else begin
            cmd_o.second_append = 1'b1;
            state_d             = ST_IN_SECOND;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_OUTSIDE;
          end
        end
      end
      ST_HALTED: begin
        state_d = ST_HALTED;
      end
    endcase
  end

  // Output word valid
  assign load        = cmd_o.load_echo | cmd_o.load_err | cmd_o.emit_step;
  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_OUTSIDE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An error word always leads into the halted state
  `CSPLIT_ASSERT(a_err_halts, cmd_o.load_err |=> (state_q == ST_HALTED), "error without halt")
  // Halted is final until reset
  `CSPLIT_ASSERT(a_halt_sticky, (state_q == ST_HALTED) |=> (state_q == ST_HALTED), "left halt")
  // No word is produced once halted
  `CSPLIT_ASSERT(a_halt_silent, (state_q == ST_HALTED) |-> !load, "word loaded while halted")
  // A load never overwrites a word that is still waiting
  `CSPLIT_ASSERT(a_no_overwrite, (out_valid_q && !out_ready_i) |-> !load, "word overwritten")

endmodule

`default_nettype wire

/* src/chord_note_splitter_core.sv */
`default_nettype none

// Chord note splitter.
// Input stream (s_axis_*): one text character per word in tdata[7:0].
// Output stream (m_axis_*): tdata[7:0] is the character, tuser flags an
// error word (tdata zero), tlast marks the final word caused by one input.
// Outside brackets each character is echoed in the cycle after acceptance.
// A bracketed chord is stored in the two halves of the part memory as it
// arrives; on ']' the chosen part (lower pitch, or higher when select_high is
// set) is sent one word per cycle while m_axis_tready is high. No input is
// taken during that emission.
// Otherwise one character is accepted per cycle while m_axis_tready is high.
// A parse error sends one error word, after which every input is accepted
// and dropped until reset.
// Reset (rst_ni low) returns to outside-chord with select_high cleared.
// When m_axis_tready is low the output word holds, and input is held off
// until that word is taken (once halted, input is still taken and dropped).
// APB register 0 (byte address 0): bit 0 = select_high.
module chord_note_splitter_core #(
  parameter int unsigned PART_MAX = csplit_pkg::PART_MAX_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // in word: [7:0] in_byte
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,
  // out word: [7:0] out_byte
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,
  // [0] error
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [csplit_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [csplit_pkg::PDATA_W-1:0]  pwdata,
  output logic [csplit_pkg::PDATA_W-1:0]       prdata,
  output logic                                 pready
);

  csplit_pkg::csplit_status_t status;
  csplit_pkg::csplit_cmd_t    cmd;
  logic                       cfg_we, select_high;

  // Register 0 decodes on word address zero
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : {{(csplit_pkg::PDATA_W-1){1'b0}}, select_high};

  csplit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  csplit_dp #(
    .PART_MAX (PART_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we),
    .cfg_bit_i     (pwdata[0]),
    .select_high_o (select_high),
    .out_byte_o    (m_axis_tdata),
    .out_err_o     (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire
